// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pdfsd_pkg.sv
// Package with the types, codes and helper functions of the PDF string decoder.
package pdfsd_pkg;

    // Decoder mode while a string is open.
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_HEX,
        MODE_FAIL
    } mode_t;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Delimiters and escape letters.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    // Control codes that the escapes stand for.
    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_HT = 8'h09;
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;

    // Escape byte after reset (backslash).
    localparam logic [7:0] ESC_RESET = 8'h5C;

    // Default depth of the result queue.
    localparam int RES_DEPTH = 4;

    // One result without its run marker.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } res_t;

    // Results that one item causes, in order.
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } dec_out_t;

    // One queued result.
    typedef struct packed {
        res_t res;
        logic last;
    } ent_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Octal digit test.
    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

endpackage

// File: hdl/pdf_string_literal_decoder_core.sv
// Top level of the PDF string decoder: ports, decoder and result queue.
//
// Input channel (s_*): one raw byte of a delimited PDF string per item, with
// s_is_first on the opening delimiter and s_is_last on the closing one.
// Result channel (m_*): decoded data bytes (kind 0), then one end marker
// (kind 1) or one error marker (kind 2); m_run_last flags the final result
// that an input item caused. An item causes zero, one or two results.
// Configuration channel (cfg_*): writes the escape byte; it is always ready
// and is meant to be written only while no item is in flight.
// Each result is written into the result queue when its item is accepted.
// Throughput: one item per cycle while items cause at most one result each
// and the receiver is ready; the result side drains one result per cycle, so
// items that cause two results fill the queue and hold the input side back.
// The result queue (FIFO_DEPTH entries) sets this: s_ready is high while at
// least two entries are free, so a stalled receiver holds results in the
// queue and the input side stops once it fills.
// Reset (aresetn low, synchronous) empties the queue, returns the decoder to
// idle and sets the escape byte to backslash.
module pdf_string_literal_decoder_core #(
    parameter int FIFO_DEPTH = pdfsd_pkg::RES_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_first,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic       m_run_last
);

    pdfsd_pkg::dec_out_t dec;
    pdfsd_pkg::ent_t     head;
    logic                room;
    logic                accept;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign accept    = s_valid && room;

    // Byte decoder.
    pdfsd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_byte  (s_in_byte),
        .is_first (s_is_first),
        .is_last  (s_is_last),
        .dec      (dec)
    );

    // Result queue.
    pdfsd_rfifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rfifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .dec     (dec),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    // Result fields.
    assign m_out_byte = head.res.data;
    assign m_kind     = head.res.kind;
    assign m_run_last = head.last;

endmodule

// File: hdl/pdfsd_decode.sv
// Per-byte decoder: string state, escape register and the result logic of one item.
module pdfsd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                is_first,
    input  logic                is_last,
    output pdfsd_pkg::dec_out_t dec
);

    pdfsd_pkg::mode_t mode_reg, mode_next;
    logic             esc_pend_reg, esc_pend_next;
    logic [1:0]       oct_cnt_reg, oct_cnt_next;
    logic [7:0]       oct_val_reg, oct_val_next;
    logic             hex_have_reg, hex_have_next;
    logic [3:0]       hex_nib_reg, hex_nib_next;
    logic [7:0]       esc_char_reg;

    logic             pre_v;
    logic [7:0]       pre_byte;
    logic             main_v;
    logic [7:0]       main_byte;
    logic [1:0]       main_kind;

    // Next string state and the results of the current byte.
    always_comb begin
        logic       handled;
        logic [4:0] hx;
        logic [1:0] cnt_inc;
        mode_next     = mode_reg;
        esc_pend_next = esc_pend_reg;
        oct_cnt_next  = oct_cnt_reg;
        oct_val_next  = oct_val_reg;
        hex_have_next = hex_have_reg;
        hex_nib_next  = hex_nib_reg;
        pre_v         = 1'b0;
        pre_byte      = 8'd0;
        main_v        = 1'b0;
        main_byte     = 8'd0;
        main_kind     = pdfsd_pkg::KIND_DATA;
        handled       = 1'b0;
        hx            = pdfsd_pkg::hex_nibble(in_byte);
        cnt_inc       = oct_cnt_reg + 2'd1;

        if (is_first) begin
            // An opening byte always restarts the string.
            esc_pend_next = 1'b0;
            oct_cnt_next  = 2'd0;
            oct_val_next  = 8'd0;
            hex_have_next = 1'b0;
            hex_nib_next  = 4'd0;
            if (in_byte == pdfsd_pkg::CH_LPAREN) begin
                mode_next = pdfsd_pkg::MODE_LIT;
            end else if (in_byte == pdfsd_pkg::CH_LT) begin
                mode_next = pdfsd_pkg::MODE_HEX;
            end else begin
                main_v    = 1'b1;
                main_kind = pdfsd_pkg::KIND_BAD;
                mode_next = is_last ? pdfsd_pkg::MODE_IDLE : pdfsd_pkg::MODE_FAIL;
            end
            if (is_last) begin
                main_v    = 1'b1;
                main_kind = pdfsd_pkg::KIND_BAD;
                mode_next = pdfsd_pkg::MODE_IDLE;
            end
        end else begin
            case (mode_reg)
                pdfsd_pkg::MODE_FAIL: begin
                    if (is_last) begin
                        mode_next = pdfsd_pkg::MODE_IDLE;
                    end
                end
                pdfsd_pkg::MODE_LIT: begin
                    // An open octal run either grows or is flushed first.
                    if (oct_cnt_reg != 2'd0) begin
                        if (!is_last && pdfsd_pkg::is_octal(in_byte)) begin
                            handled      = 1'b1;
                            oct_val_next = {oct_val_reg[4:0], in_byte[2:0]};
                            oct_cnt_next = cnt_inc;
                            if (cnt_inc == 2'd3) begin
                                main_v       = 1'b1;
                                main_byte    = {oct_val_reg[4:0], in_byte[2:0]};
                                oct_cnt_next = 2'd0;
                                oct_val_next = 8'd0;
                            end
                        end else begin
                            pre_v        = 1'b1;
                            pre_byte     = oct_val_reg;
                            oct_cnt_next = 2'd0;
                            oct_val_next = 8'd0;
                        end
                    end
                    if (!handled) begin
                        if (is_last) begin
                            main_v    = 1'b1;
                            main_kind = (!esc_pend_reg && in_byte == pdfsd_pkg::CH_RPAREN) ?
                                        pdfsd_pkg::KIND_END : pdfsd_pkg::KIND_BAD;
                            mode_next     = pdfsd_pkg::MODE_IDLE;
                            esc_pend_next = 1'b0;
                            oct_cnt_next  = 2'd0;
                            oct_val_next  = 8'd0;
                        end else if (esc_pend_reg) begin
                            // Byte after the escape byte.
                            esc_pend_next = 1'b0;
                            main_v        = 1'b1;
                            if (in_byte == esc_char_reg) begin
                                main_byte = in_byte;
                            end else if (in_byte == pdfsd_pkg::CH_N) begin
                                main_byte = pdfsd_pkg::CODE_LF;
                            end else if (in_byte == pdfsd_pkg::CH_R) begin
                                main_byte = pdfsd_pkg::CODE_CR;
                            end else if (in_byte == pdfsd_pkg::CH_T) begin
                                main_byte = pdfsd_pkg::CODE_HT;
                            end else if (in_byte == pdfsd_pkg::CH_B) begin
                                main_byte = pdfsd_pkg::CODE_BS;
                            end else if (in_byte == pdfsd_pkg::CH_F) begin
                                main_byte = pdfsd_pkg::CODE_FF;
                            end else if (in_byte == pdfsd_pkg::CH_LPAREN ||
                                         in_byte == pdfsd_pkg::CH_RPAREN) begin
                                main_byte = in_byte;
                            end else if (pdfsd_pkg::is_octal(in_byte)) begin
                                main_v       = 1'b0;
                                oct_cnt_next = 2'd1;
                                oct_val_next = {5'd0, in_byte[2:0]};
                            end else begin
                                main_kind     = pdfsd_pkg::KIND_BAD;
                                mode_next     = pdfsd_pkg::MODE_FAIL;
                                esc_pend_next = 1'b0;
                                oct_cnt_next  = 2'd0;
                                oct_val_next  = 8'd0;
                            end
                        end else if (in_byte == esc_char_reg) begin
                            esc_pend_next = 1'b1;
                        end else begin
                            main_v    = 1'b1;
                            main_byte = in_byte;
                        end
                    end
                end
                pdfsd_pkg::MODE_HEX: begin
                    if (is_last) begin
                        main_v = 1'b1;
                        if (in_byte == pdfsd_pkg::CH_GT) begin
                            // An odd final digit is padded with a zero nibble.
                            pre_v     = hex_have_reg;
                            pre_byte  = {hex_nib_reg, 4'd0};
                            main_kind = pdfsd_pkg::KIND_END;
                        end else begin
                            main_kind = pdfsd_pkg::KIND_BAD;
                        end
                        mode_next     = pdfsd_pkg::MODE_IDLE;
                        hex_have_next = 1'b0;
                        hex_nib_next  = 4'd0;
                    end else if (!hx[4]) begin
                        main_v        = 1'b1;
                        main_kind     = pdfsd_pkg::KIND_BAD;
                        mode_next     = pdfsd_pkg::MODE_FAIL;
                        hex_have_next = 1'b0;
                        hex_nib_next  = 4'd0;
                    end else if (hex_have_reg) begin
                        main_v        = 1'b1;
                        main_byte     = {hex_nib_reg, hx[3:0]};
                        hex_have_next = 1'b0;
                        hex_nib_next  = 4'd0;
                    end else begin
                        hex_have_next = 1'b1;
                        hex_nib_next  = hx[3:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Pack the results in order: a flushed byte comes before the main result.
    always_comb begin
        dec.r0 = '0;
        dec.r1 = '0;
        if (pre_v) begin
            dec.r0.data = pre_byte;
            dec.r0.kind = pdfsd_pkg::KIND_DATA;
            dec.r1.data = main_byte;
            dec.r1.kind = main_kind;
            dec.count   = main_v ? 2'd2 : 2'd1;
        end else begin
            dec.r0.data = main_byte;
            dec.r0.kind = main_kind;
            dec.count   = main_v ? 2'd1 : 2'd0;
        end
    end

    // String state, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= pdfsd_pkg::MODE_IDLE;
            esc_pend_reg <= 1'b0;
            oct_cnt_reg  <= 2'd0;
            oct_val_reg  <= 8'd0;
            hex_have_reg <= 1'b0;
            hex_nib_reg  <= 4'd0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            esc_pend_reg <= esc_pend_next;
            oct_cnt_reg  <= oct_cnt_next;
            oct_val_reg  <= oct_val_next;
            hex_have_reg <= hex_have_next;
            hex_nib_reg  <= hex_nib_next;
        end
    end

    // Escape byte register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_char_reg <= pdfsd_pkg::ESC_RESET;
        end else if (cfg_we) begin
            esc_char_reg <= cfg_data;
        end
    end

endmodule

// File: hdl/pdfsd_rfifo.sv
// Result queue: takes up to two results per cycle and hands one out per cycle while the receiver is ready.
module pdfsd_rfifo #(
    parameter int DEPTH = pdfsd_pkg::RES_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pdfsd_pkg::dec_out_t dec,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output pdfsd_pkg::ent_t     head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pdfsd_pkg::ent_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   wr_plus1;
    logic [1:0]      n_push;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointer and fill count arithmetic.
    always_comb begin
        n_push   = push ? dec.count : 2'd0;
        pop      = m_valid && m_ready;
        wr_plus1 = ptr_inc(wr_reg);
        case (n_push)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = ptr_inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(n_push) - CW'(pop);
    end

    // Room for the two results the worst item can cause.
    assign room    = (cnt_reg <= CW'(DEPTH - 2));
    assign m_valid = (cnt_reg != '0);
    assign head    = mem_reg[rd_reg];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result storage; the last result of an item carries the run marker.
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem_reg[wr_reg] <= '{res: dec.r0, last: (n_push == 2'd1)};
        end
        if (n_push == 2'd2) begin
            mem_reg[wr_plus1] <= '{res: dec.r1, last: 1'b1};
        end
    end

endmodule

// File: hdl/pdfsd_checker.sv
// Port-level checker for the PDF string decoder, bound to the top level.
`include "assert_macros.svh"

module pdfsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [7:0] cfg_data,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_is_first,
    input logic       s_is_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_kind,
    input logic       m_run_last
);

    // End and error markers carry a zero byte and close the run of their item.
    property p_mark_zero;
        m_valid && m_kind != pdfsd_pkg::KIND_DATA |-> m_out_byte == 8'd0 && m_run_last;
    endproperty

    // A stalled result stays offered.
    `ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")

    // No result is offered in the cycle after reset.
    `ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "result offered after reset")

    // Only the three defined kinds appear.
    `ASSERT_CLK(a_kind, aclk, aresetn, m_valid |-> m_kind <= pdfsd_pkg::KIND_BAD, "bad kind")

    `ASSERT_CLK(a_mark_zero, aclk, aresetn, p_mark_zero, "marker with data or not last")

endmodule

bind pdf_string_literal_decoder_core pdfsd_checker u_pdfsd_checker (.*);
